@@ design/rhh_pkg.sv @@
`timescale 1ns / 1ps
// shared types for the rgb hue rotation pipeline
package rhh_pkg;

   // pixel data that rides along the analysis and divider stages
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  min_val;
      logic [7:0]  delta;
      logic        gray;
      logic [15:0] lightness;
   } rhh_pix_type;

endpackage

@@ design/rhh_req_if.sv @@
`timescale 1ns / 1ps
// pixel request channel
interface rhh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

@@ design/rhh_rsp_if.sv @@
`timescale 1ns / 1ps
// rotated pixel response channel
interface rhh_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;
   logic [15:0] hue_in;
   logic [15:0] saturation_in;
   logic [15:0] lightness_in;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output hue_in, output saturation_in, output lightness_in, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input hue_in, input saturation_in, input lightness_in, output ready);
endinterface

@@ design/rhh_analyze.sv @@
`timescale 1ns / 1ps
// two analysis stages: channel extremes, lightness and divider operands
module rhh_analyze (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [7:0]          red,
   input  logic [7:0]          green,
   input  logic [7:0]          blue,
   output logic                out_valid,
   output rhh_pkg::rhh_pix_type out_pix,
   output logic [23:0]         sat_num,
   output logic [7:0]          sat_den,
   output logic [10:0]         hue_num,
   output logic [10:0]         hue_den
);

   typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_type;

   logic        v1_ff, v2_ff;
   logic [7:0]  r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   logic [7:0]  mx1_in, mn1_in;
   max_sel_type sel1_ff, sel1_in;

   rhh_pkg::rhh_pix_type pix2_ff, pix2_in;
   logic [23:0] snum2_ff, snum2_in;
   logic [7:0]  sden2_ff, sden2_in;
   logic [10:0] hnum2_ff, hnum2_in;
   logic [10:0] hden2_ff, hden2_in;

   // stage 1: max with red, green, blue priority, and min
   always_comb begin
      mx1_in  = red;
      sel1_in = MAX_RED;
      if (green > mx1_in) begin
         mx1_in  = green;
         sel1_in = MAX_GREEN;
      end
      if (blue > mx1_in) begin
         mx1_in  = blue;
         sel1_in = MAX_BLUE;
      end
      mn1_in = red;
      if (green < mn1_in) mn1_in = green;
      if (blue < mn1_in) mn1_in = blue;
   end

   // stage 2: delta, sum, lightness, saturation and hue operands
   always_comb begin : stage2
      logic [7:0]  delta;
      logic [8:0]  sum;
      logic [10:0] d6;
      logic [10:0] base;
      logic [7:0]  plus_term;
      logic [7:0]  minus_term;
      logic [11:0] tmp;
      delta = mx1_ff - mn1_ff;
      sum   = {1'b0, mx1_ff} + {1'b0, mn1_ff};
      d6    = 11'({1'b0, delta, 2'b00}) + 11'({2'b00, delta, 1'b0});
      case (sel1_ff)
         MAX_RED: begin
            base       = '0;
            plus_term  = g1_ff;
            minus_term = b1_ff;
         end
         MAX_GREEN: begin
            base       = 11'({2'b00, delta, 1'b0});
            plus_term  = b1_ff;
            minus_term = r1_ff;
         end
         default: begin
            base       = 11'({1'b0, delta, 2'b00});
            plus_term  = r1_ff;
            minus_term = g1_ff;
         end
      endcase
      // always at least 5*delta, so no underflow
      tmp = {1'b0, d6} + {1'b0, base} + 12'(plus_term) - 12'(minus_term);
      if (tmp >= {1'b0, d6}) tmp = tmp - {1'b0, d6};
      hnum2_in = tmp[10:0];
      hden2_in = d6;

      pix2_in.red       = r1_ff;
      pix2_in.green     = g1_ff;
      pix2_in.blue      = b1_ff;
      pix2_in.min_val   = mn1_ff;
      pix2_in.delta     = delta;
      pix2_in.gray      = (delta == 8'd0);
      // sum * 65535 / 510 is exactly sum * 257 / 2
      pix2_in.lightness = 16'(({sum, 8'b0} + 17'(sum)) >> 1);

      snum2_in = {delta, 16'b0} - 24'(delta);
      if (sum <= 9'd255) sden2_in = sum[7:0];
      else sden2_in = 8'(10'd510 - {1'b0, sum});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= red;
         g1_ff    <= green;
         b1_ff    <= blue;
         mx1_ff   <= mx1_in;
         mn1_ff   <= mn1_in;
         sel1_ff  <= sel1_in;
         pix2_ff  <= pix2_in;
         snum2_ff <= snum2_in;
         sden2_ff <= sden2_in;
         hnum2_ff <= hnum2_in;
         hden2_ff <= hden2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_pix   = pix2_ff;
   assign sat_num   = snum2_ff;
   assign sat_den   = sden2_ff;
   assign hue_num   = hnum2_ff;
   assign hue_den   = hden2_ff;

endmodule

@@ design/rhh_div.sv @@
`timescale 1ns / 1ps
// pipelined restoring dividers for saturation and hue, up to four quotient bits per stage
module rhh_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  rhh_pkg::rhh_pix_type     in_pix,
   input  logic [23:0]              sat_num,
   input  logic [7:0]               sat_den,
   input  logic [10:0]              hue_num,
   input  logic [10:0]              hue_den,
   output logic                     out_valid,
   output rhh_pkg::rhh_pix_type     out_pix,
   output logic [15:0]              out_sat,
   output logic [FRACTION_BITS-1:0] out_hue
);

   localparam int QMAX    = (FRACTION_BITS > 16) ? FRACTION_BITS : 16;
   localparam int STAGES  = (QMAX + 3) / 4;
   localparam int SAT_SPS = (16 + STAGES - 1) / STAGES;
   localparam int HUE_SPS = (FRACTION_BITS + STAGES - 1) / STAGES;

   logic                     valid_w [STAGES+1];
   rhh_pkg::rhh_pix_type     pix_w   [STAGES+1];
   logic [7:0]               srem_w  [STAGES+1];
   logic [15:0]              sword_w [STAGES+1];
   logic [7:0]               sden_w  [STAGES+1];
   logic [10:0]              hrem_w  [STAGES+1];
   logic [FRACTION_BITS-1:0] hword_w [STAGES+1];
   logic [10:0]              hden_w  [STAGES+1];

   // for a colored pixel the partial remainder starts below the divisor, quotient bits shift in at the bottom
   assign valid_w[0] = in_valid;
   assign pix_w[0]   = in_pix;
   assign srem_w[0]  = sat_num[23:16];
   assign sword_w[0] = sat_num[15:0];
   assign sden_w[0]  = sat_den;
   assign hrem_w[0]  = hue_num;
   assign hword_w[0] = '0;
   assign hden_w[0]  = hue_den;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                     valid_ff;
      rhh_pkg::rhh_pix_type     pix_ff;
      logic [7:0]               srem_ff, srem_in, sden_ff;
      logic [15:0]              sword_ff, sword_in;
      logic [10:0]              hrem_ff, hrem_in, hden_ff;
      logic [FRACTION_BITS-1:0] hword_ff, hword_in;

      always_comb begin : div_step
         logic [8:0]  st;
         logic [11:0] ht;
         srem_in  = srem_w[s];
         sword_in = sword_w[s];
         hrem_in  = hrem_w[s];
         hword_in = hword_w[s];
         st = '0;
         ht = '0;
         for (int j = 0; j < SAT_SPS; j++) begin
            if (s * SAT_SPS + j < 16) begin
               st       = {srem_in, sword_in[15]};
               sword_in = {sword_in[14:0], 1'b0};
               if (st >= {1'b0, sden_w[s]}) begin
                  srem_in     = 8'(st - {1'b0, sden_w[s]});
                  sword_in[0] = 1'b1;
               end else begin
                  srem_in = st[7:0];
               end
            end
         end
         for (int j = 0; j < HUE_SPS; j++) begin
            if (s * HUE_SPS + j < FRACTION_BITS) begin
               ht       = {hrem_in, hword_in[FRACTION_BITS-1]};
               hword_in = {hword_in[FRACTION_BITS-2:0], 1'b0};
               if (ht >= {1'b0, hden_w[s]}) begin
                  hrem_in     = 11'(ht - {1'b0, hden_w[s]});
                  hword_in[0] = 1'b1;
               end else begin
                  hrem_in = ht[10:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pix_ff   <= pix_w[s];
            srem_ff  <= srem_in;
            sword_ff <= sword_in;
            sden_ff  <= sden_w[s];
            hrem_ff  <= hrem_in;
            hword_ff <= hword_in;
            hden_ff  <= hden_w[s];
         end
      end

      assign valid_w[s+1] = valid_ff;
      assign pix_w[s+1]   = pix_ff;
      assign srem_w[s+1]  = srem_ff;
      assign sword_w[s+1] = sword_ff;
      assign sden_w[s+1]  = sden_ff;
      assign hrem_w[s+1]  = hrem_ff;
      assign hword_w[s+1] = hword_ff;
      assign hden_w[s+1]  = hden_ff;
   end

   assign out_valid = valid_w[STAGES];
   assign out_pix   = pix_w[STAGES];
   assign out_sat   = sword_w[STAGES];
   assign out_hue   = hword_w[STAGES];

endmodule

@@ design/rhh_rebuild.sv @@
`timescale 1ns / 1ps
// hue offset, channel curves and output register
module rhh_rebuild #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  rhh_pkg::rhh_pix_type     in_pix,
   input  logic [15:0]              in_sat,
   input  logic [FRACTION_BITS-1:0] in_hue,
   input  logic [15:0]              hue_offset,
   output logic                     out_valid,
   output logic [7:0]               out_red,
   output logic [7:0]               out_green,
   output logic [7:0]               out_blue,
   output logic [15:0]              out_hue,
   output logic [15:0]              out_sat,
   output logic [15:0]              out_light
);

   localparam int FB = FRACTION_BITS;
   localparam int UW = FB + 4;
   localparam int PW = FB + 9;
   localparam logic [UW-1:0] T1 = UW'(1) << FB;
   localparam logic [UW-1:0] T2 = UW'(2) << FB;
   localparam logic [UW-1:0] T3 = UW'(3) << FB;
   localparam logic [UW-1:0] T4 = UW'(4) << FB;
   localparam logic [UW-1:0] T6 = UW'(6) << FB;

   typedef enum logic [1:0] {SEG_RISE, SEG_TOP, SEG_FALL, SEG_ZERO} seg_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   rhh_pkg::rhh_pix_type pix1_ff, pix2_ff, pix3_ff;
   logic [15:0] hue1_ff, sat1_ff, hue2_ff, sat2_ff, hue3_ff, sat3_ff;
   logic [FB-1:0] h1_ff, h1_in;
   logic [15:0] hue1_in, sat1_in;
   logic [UW-1:0] u2_ff [3];
   logic [UW-1:0] u2_in [3];
   logic [PW-1:0] prod3_ff [3];
   logic [PW-1:0] prod3_in [3];
   seg_type seg3_ff [3];
   seg_type seg3_in [3];
   logic [7:0] chan4_ff [3];
   logic [7:0] chan4_in [3];
   logic [15:0] hue4_ff, sat4_ff, light4_ff;

   // stage 1: add the aligned offset, wrap modulo one turn, zero hue and saturation of gray pixels
   always_comb begin : stage1
      logic [FB-1:0] off;
      off     = FB'(({hue_offset, {FB{1'b0}}}) >> 16);
      h1_in   = in_hue + off;
      hue1_in = in_pix.gray ? 16'd0 : 16'(({in_hue, 16'b0}) >> FB);
      sat1_in = in_pix.gray ? 16'd0 : in_sat;
   end

   // stage 2: curve positions for red, green and blue
   always_comb begin : stage2
      logic [UW-1:0] u;
      logic [UW-1:0] ur;
      logic [UW-1:0] ub;
      u  = UW'({h1_ff, 2'b00}) + UW'({h1_ff, 1'b0});
      ur = u + T2;
      if (ur >= T6) ur = ur - T6;
      ub = u + T4;
      if (ub >= T6) ub = ub - T6;
      u2_in[0] = ur;
      u2_in[1] = u;
      u2_in[2] = ub;
   end

   // stage 3: segment of the curve and delta times the ramp
   always_comb begin : stage3
      logic [UW-1:0] x;
      for (int c = 0; c < 3; c++) begin
         x = '0;
         if (u2_ff[c] < T1) begin
            seg3_in[c] = SEG_RISE;
            x          = u2_ff[c];
         end else if (u2_ff[c] < T3) begin
            seg3_in[c] = SEG_TOP;
         end else if (u2_ff[c] < T4) begin
            seg3_in[c] = SEG_FALL;
            x          = T4 - u2_ff[c];
         end else begin
            seg3_in[c] = SEG_ZERO;
         end
         prod3_in[c] = PW'(pix2_ff.delta) * PW'(x);
      end
   end

   // stage 4: min plus the truncated ramp, plus delta on the top segment, plus nothing on the zero segment
   always_comb begin : stage4
      logic [7:0] add;
      for (int c = 0; c < 3; c++) begin
         case (seg3_ff[c]) inside
            SEG_RISE, SEG_FALL: add = prod3_ff[c][FB+7:FB];
            SEG_TOP:            add = pix3_ff.delta;
            default:            add = 8'd0;
         endcase
         chan4_in[c] = pix3_ff.min_val + add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix1_ff   <= in_pix;
         h1_ff     <= h1_in;
         hue1_ff   <= hue1_in;
         sat1_ff   <= sat1_in;
         pix2_ff   <= pix1_ff;
         u2_ff     <= u2_in;
         hue2_ff   <= hue1_ff;
         sat2_ff   <= sat1_ff;
         pix3_ff   <= pix2_ff;
         prod3_ff  <= prod3_in;
         seg3_ff   <= seg3_in;
         hue3_ff   <= hue2_ff;
         sat3_ff   <= sat2_ff;
         chan4_ff  <= chan4_in;
         hue4_ff   <= hue3_ff;
         sat4_ff   <= sat3_ff;
         light4_ff <= pix3_ff.lightness;
      end
   end

   assign out_valid = v4_ff;
   assign out_red   = chan4_ff[0];
   assign out_green = chan4_ff[1];
   assign out_blue  = chan4_ff[2];
   assign out_hue   = hue4_ff;
   assign out_sat   = sat4_ff;
   assign out_light = light4_ff;

endmodule

@@ design/rgb_hsl_hue_rotate_unit.sv @@
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the response channel is not stalled
// the two dividers retire up to four quotient bits a stage
// a response not taken stalls every stage at once, so nothing is dropped or repeated
// reset (synchronous, active high) clears all valid bits and sets hue_offset to 0
module rgb_hsl_hue_rotate_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   rhh_req_if.sink      req_if,
   rhh_rsp_if.source    rsp_if,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic        en;
   logic [15:0] hue_offset_ff;

   logic                 a_valid;
   rhh_pkg::rhh_pix_type a_pix;
   logic [23:0]          a_sat_num;
   logic [7:0]           a_sat_den;
   logic [10:0]          a_hue_num;
   logic [10:0]          a_hue_den;

   logic                     d_valid;
   rhh_pkg::rhh_pix_type     d_pix;
   logic [15:0]              d_sat;
   logic [FRACTION_BITS-1:0] d_hue;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= '0;
      end else if (csr_wr_en) begin
         hue_offset_ff <= csr_wr_data;
      end
   end

   // whole pipeline moves unless the output register holds an untaken transaction
   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   rhh_analyze u_analyze (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .red       (req_if.red_in),
      .green     (req_if.green_in),
      .blue      (req_if.blue_in),
      .out_valid (a_valid),
      .out_pix   (a_pix),
      .sat_num   (a_sat_num),
      .sat_den   (a_sat_den),
      .hue_num   (a_hue_num),
      .hue_den   (a_hue_den)
   );

   rhh_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid),
      .in_pix    (a_pix),
      .sat_num   (a_sat_num),
      .sat_den   (a_sat_den),
      .hue_num   (a_hue_num),
      .hue_den   (a_hue_den),
      .out_valid (d_valid),
      .out_pix   (d_pix),
      .out_sat   (d_sat),
      .out_hue   (d_hue)
   );

   rhh_rebuild #(.FRACTION_BITS(FRACTION_BITS)) u_rebuild (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (d_valid),
      .in_pix     (d_pix),
      .in_sat     (d_sat),
      .in_hue     (d_hue),
      .hue_offset (hue_offset_ff),
      .out_valid  (rsp_if.valid),
      .out_red    (rsp_if.red_out),
      .out_green  (rsp_if.green_out),
      .out_blue   (rsp_if.blue_out),
      .out_hue    (rsp_if.hue_in),
      .out_sat    (rsp_if.saturation_in),
      .out_light  (rsp_if.lightness_in)
   );

   // zero saturation happens only for gray pixels, which pass unchanged
   a_gray_passes: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturation_in == 16'd0 |->
         rsp_if.red_out == rsp_if.green_out && rsp_if.green_out == rsp_if.blue_out
         && rsp_if.hue_in == 16'd0)
      else $error("gray transaction not passed through");

   // gray lightness is 257 times the channel value
   a_gray_light: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturation_in == 16'd0 |->
         rsp_if.lightness_in == ({rsp_if.red_out, 8'b0} + 16'(rsp_if.red_out)))
      else $error("gray lightness mismatch");

   // a colored pixel keeps one channel at max and one at min, so never all equal
   a_color_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturation_in != 16'd0 |->
         !(rsp_if.red_out == rsp_if.green_out && rsp_if.green_out == rsp_if.blue_out))
      else $error("colored transaction lost its channel spread");

endmodule
